FILE: rtl/core/hashed_id_to_slot_map_macros.svh
// Assertion macros of the hashed id to slot map RTL, used by its datapath.
`ifndef HASHED_ID_TO_SLOT_MAP_MACROS_SVH
`define HASHED_ID_TO_SLOT_MAP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HISM_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HISM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hism_pkg.sv
// Package with shared types and constants of the hashed id to slot map.
`default_nettype none

package hism_pkg;

    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 6;
    localparam int STATUS_W = 2;

    // Hash finalizer multipliers
    localparam logic [KEY_W-1:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [KEY_W-1:0] MIX_C2 = 32'hc2b2_ae35;

    // Slot reduction for non power-of-two slot counts: hash bits per digit and digit steps
    localparam int MOD_DIGIT_W = 8;
    localparam int MOD_STEPS   = KEY_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    // Request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL1  = 8'b0000_0100,
        S_MUL2  = 8'b0000_1000,
        S_MOD   = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ready;
        logic accept;
        logic mul1;
        logic mul2;
        logic mod_step;
        logic probe_next;
        logic insert;
        logic finish;
        logic refuse;
        logic emit;
        logic clear_step;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic refuse_in;
        logic mod_done;
        logic hit;
        logic empty;
        logic last_try;
        logic find;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/hism_ctrl.sv
// Controller state machine of the hashed id to slot map.
`default_nettype none

module hism_ctrl
    import hism_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold state, restart with the slot clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode state and status into commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.refuse_in) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.refuse = 1'b1;
                        n_state      = i_sts.out_free ? S_IDLE : S_EMIT;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit || i_sts.empty || i_sts.last_try) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.insert = i_sts.empty && !i_sts.find;
                    n_state      = i_sts.out_free ? S_IDLE : S_EMIT;
                end else begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/hism_dp.sv
// Datapath of the hashed id to slot map: hash, slot reduction, slot memory, result.
`default_nettype none

`include "hashed_id_to_slot_map_macros.svh"

module hism_dp
    import hism_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int SLOT_COUNT  = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic                i_command,
    input  wire logic [KEY_W-1:0]    i_key,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output logic [ENTRY_W-1:0]       o_entry,
    output logic [STATUS_W-1:0]      o_status
);

    localparam int  SW      = $clog2(SLOT_COUNT);
    localparam int  EW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int  CW      = $clog2(MAX_ENTRIES + 1);
    localparam int  MW      = 1 + EW + KEY_W;
    localparam bit  IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] ENTRY_MAX = CW'(MAX_ENTRIES);

    logic                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_W-1:0]    r_prod;
    logic [SW-1:0]       r_slot;
    logic [SW-1:0]       r_tries;
    logic [CW-1:0]       r_count;
    logic [MW-1:0]       r_mem [SLOT_COUNT];
    logic [MW-1:0]       r_rd;
    logic [ENTRY_W-1:0]  r_res_entry;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_o_valid;
    logic [ENTRY_W-1:0]  r_o_entry;
    logic [STATUS_W-1:0] r_o_status;

    logic [KEY_W-1:0]    mix1;
    logic [KEY_W-1:0]    mix2;
    logic [KEY_W-1:0]    mix3;
    logic [SW-1:0]       mod_rem;
    logic                mod_done;
    logic [SW-1:0]       slot_nxt;
    logic [SW-1:0]       mem_ra;
    logic                mem_we;
    logic [MW-1:0]       mem_wd;
    logic                rd_used;
    logic [EW-1:0]       rd_entry;
    logic [KEY_W-1:0]    rd_key;
    logic                hit;
    logic                full;
    logic                find;
    logic                out_free;
    logic [EW-1:0]       res_ent;
    logic [EW+ENTRY_W-1:0] ent_ext;
    logic [STATUS_W-1:0] res_status;

    // Hash mixing steps around the two registered multiplies
    assign mix1 = r_key ^ (r_key >> 16);
    assign mix2 = r_prod ^ (r_prod >> 13);
    assign mix3 = r_prod ^ (r_prod >> 16);

    // Reduce the hash to a slot index
    generate
        if (IS_POW2) begin : g_mask
            assign mod_rem  = mix3[SW-1:0];
            assign mod_done = 1'b1;
        end else begin : g_serial
            localparam logic [SW:0] SLOT_CNT_W = (SW + 1)'(SLOT_COUNT);

            logic [MOD_CNT_W-1:0] r_mod_cnt;
            logic [KEY_W-1:0]     r_hsh;
            logic [KEY_W-1:0]     src;
            logic [SW-1:0]        rem;
            logic [SW:0]          trial;

            // Restoring remainder, one digit of the hash per cycle, msb first
            always_comb begin
                src = (r_mod_cnt == '0) ? mix3 : r_hsh;
                rem = (r_mod_cnt == '0) ? '0 : r_slot;
                for (int i = 0; i < MOD_DIGIT_W; i++) begin
                    trial = {rem, src[KEY_W-1-i]};
                    if (trial >= SLOT_CNT_W) begin
                        trial = trial - SLOT_CNT_W;
                    end
                    rem = trial[SW-1:0];
                end
            end

            assign mod_rem  = rem;
            assign mod_done = r_mod_cnt == MOD_CNT_W'(MOD_STEPS - 1);

            // Advance the digit counter and the remaining hash bits
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mod_cnt <= '0;
                end else if (i_cmd.mod_step) begin
                    r_mod_cnt <= r_mod_cnt + MOD_CNT_W'(1);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.mod_step) begin
                    r_hsh <= src << MOD_DIGIT_W;
                end
            end
        end
    endgenerate

    // Probe and clearing walk, wrapping at the slot count
    assign slot_nxt = (r_slot == SLOT_LAST) ? '0 : r_slot + SW'(1);

    // Slot memory port control
    assign mem_ra = i_cmd.probe_next ? slot_nxt : r_slot;
    assign mem_we = i_cmd.clear_step || i_cmd.insert;
    assign mem_wd = i_cmd.clear_step ? '0 : {1'b1, r_count[EW-1:0], r_key};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    assign rd_used  = r_rd[MW-1];
    assign rd_entry = r_rd[KEY_W +: EW];
    assign rd_key   = r_rd[KEY_W-1:0];

    assign hit      = rd_used && (rd_key == r_key);
    assign full     = r_count >= ENTRY_MAX;
    assign find     = r_cmd == CMD_FIND;
    assign out_free = !r_o_valid || !i_stall;

    // Form the result of the finishing transaction
    always_comb begin
        res_ent    = '0;
        res_status = ST_FULL;
        if (i_cmd.refuse) begin
            res_status = ST_FULL;
        end else if (hit) begin
            res_ent    = rd_entry;
            res_status = ST_FOUND;
        end else if (!rd_used) begin
            if (find) begin
                res_status = ST_MISSING;
            end else begin
                res_ent    = r_count[EW-1:0];
                res_status = ST_INSERTED;
            end
        end else begin
            res_status = find ? ST_MISSING : ST_FULL;
        end
    end

    assign ent_ext = {ENTRY_W'(0), res_ent};

    // Control registers: walk position, entry count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step || i_cmd.probe_next) begin
                r_slot <= slot_nxt;
            end else if (i_cmd.mod_step) begin
                r_slot <= mod_rem;
            end
            if (i_cmd.insert) begin
                r_count <= r_count + CW'(1);
            end
            if ((i_cmd.finish && out_free) || i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers: request, hash, probe count, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
        end
        if (i_cmd.mul1) begin
            r_prod <= mix1 * MIX_C1;
        end else if (i_cmd.mul2) begin
            r_prod <= mix2 * MIX_C2;
        end
        if (i_cmd.mod_step) begin
            r_tries <= '0;
        end else if (i_cmd.probe_next) begin
            r_tries <= r_tries + SW'(1);
        end
        if (i_cmd.finish) begin
            if (out_free) begin
                r_o_entry  <= ent_ext[ENTRY_W-1:0];
                r_o_status <= res_status;
            end else begin
                r_res_entry  <= ent_ext[ENTRY_W-1:0];
                r_res_status <= res_status;
            end
        end else if (i_cmd.emit) begin
            r_o_entry  <= r_res_entry;
            r_o_status <= r_res_status;
        end
    end

    assign o_sts.clear_last = r_slot == SLOT_LAST;
    assign o_sts.refuse_in  = (i_command == CMD_INSERT) && full;
    assign o_sts.mod_done   = mod_done;
    assign o_sts.hit        = hit;
    assign o_sts.empty      = !rd_used;
    assign o_sts.last_try   = r_tries == SLOT_LAST;
    assign o_sts.find       = find;
    assign o_sts.out_free   = out_free;

    assign o_valid  = r_o_valid;
    assign o_entry  = r_o_entry;
    assign o_status = r_o_status;

    // Allocation and probing checks
    `HISM_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, i_cmd.insert,
        r_count == CW'($past(r_count) + CW'(1)), "entry count did not advance on insert")
    `HISM_ASSERT_SAME(a_insert_legal, i_clk, i_rst_n, i_cmd.insert,
        !rd_used && !find && !full, "insert into used slot, on find, or when full")
    `HISM_ASSERT_SAME(a_probe_legal, i_clk, i_rst_n, i_cmd.probe_next,
        rd_used && !hit && (r_tries != SLOT_LAST), "probe advanced past a final slot")

endmodule

`default_nettype wire

FILE: rtl/core/hashed_id_to_slot_map.sv
// A request passes from acceptance through the two registered hash multiplies, the slot
// reduction and one slot memory read per probe before its result is registered; slot
// counts that are not a power of two use the 8-bit-per-cycle serial slot reduction. A new
// request is taken only after the previous one has finished and its result has been placed
// in the output register. Reset is synchronous: after it the slot memory is cleared one
// slot per cycle with the input stalled.
`default_nettype none

module hashed_id_to_slot_map
    import hism_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int SLOT_COUNT  = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_command,
    input  wire logic [KEY_W-1:0]    i_key,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [ENTRY_W-1:0]       o_entry,
    output logic [STATUS_W-1:0]      o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence each transaction
    hism_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Hash, probe and answer
    hism_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_command (i_command),
        .i_key     (i_key),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_entry   (o_entry),
        .o_status  (o_status)
    );

    assign o_stall = !w_cmd.ready;

endmodule

`default_nettype wire

FILE: tb/tb_hashed_id_to_slot_map.sv
// Self-checking testbench for the hashed id to slot map: directed table, then random traffic.
module tb_hashed_id_to_slot_map;
    timeunit 1ns;
    timeprecision 1ps;

    import hism_pkg::*;

    localparam int MAX_ENTRIES  = 64;
    localparam int SLOT_COUNT   = 128;
    localparam int RANDOM_ITEMS = 1730;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int NUM_COLLIDE  = 4;

    typedef struct packed {
        logic [ENTRY_W-1:0]  entry;
        logic [STATUS_W-1:0] status;
    } t_answer;

    typedef struct packed {
        logic               cmd;
        logic               use_collide;
        logic [KEY_W-1:0]   key;
        logic               fixed;
        logic [ENTRY_W-1:0] entry;
        logic [STATUS_W-1:0] status;
    } t_dir_row;

    // Rows with use_collide set take key as an index into the colliding key set
    localparam int NUM_DIRECTED = 20;
    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        '{CMD_FIND,   1'b0, 32'h0000_0000, 1'b1, 6'd0, ST_MISSING},
        '{CMD_FIND,   1'b0, 32'hffff_ffff, 1'b1, 6'd0, ST_MISSING},
        '{CMD_INSERT, 1'b0, 32'h0000_0000, 1'b1, 6'd0, ST_INSERTED},
        '{CMD_INSERT, 1'b0, 32'hffff_ffff, 1'b1, 6'd1, ST_INSERTED},
        '{CMD_INSERT, 1'b0, 32'h0000_0000, 1'b1, 6'd0, ST_FOUND},
        '{CMD_FIND,   1'b0, 32'hffff_ffff, 1'b1, 6'd1, ST_FOUND},
        '{CMD_FIND,   1'b0, 32'h0000_0000, 1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b1, 32'd0,         1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b1, 32'd1,         1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b1, 32'd2,         1'b0, 6'd0, ST_FOUND},
        '{CMD_FIND,   1'b1, 32'd2,         1'b0, 6'd0, ST_FOUND},
        '{CMD_FIND,   1'b1, 32'd1,         1'b0, 6'd0, ST_FOUND},
        '{CMD_FIND,   1'b1, 32'd3,         1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b1, 32'd1,         1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b0, 32'h8000_0000, 1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b0, 32'h0000_0001, 1'b0, 6'd0, ST_FOUND},
        '{CMD_FIND,   1'b0, 32'h7fff_ffff, 1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b0, 32'haaaa_aaaa, 1'b0, 6'd0, ST_FOUND},
        '{CMD_INSERT, 1'b0, 32'h5555_5555, 1'b0, 6'd0, ST_FOUND},
        '{CMD_FIND,   1'b0, 32'h5555_5555, 1'b0, 6'd0, ST_FOUND}
    };

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic                i_command = CMD_INSERT;
    logic [KEY_W-1:0]    i_key     = '0;
    logic                i_stall   = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [ENTRY_W-1:0]  o_entry;
    logic [STATUS_W-1:0] o_status;

    // Shadow copy of the table
    bit               slot_used  [SLOT_COUNT];
    int               slot_entry [SLOT_COUNT];
    logic [KEY_W-1:0] entry_key  [MAX_ENTRIES];
    int               entries_used;

    t_answer          awaited_answers [$];
    logic [KEY_W-1:0] known_keys [$];
    logic [KEY_W-1:0] collide_keys [NUM_COLLIDE];
    int               src_idle_pct;
    int               dst_idle_pct;
    int               error_count;
    int               quiet_cycles;

    hashed_id_to_slot_map #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .SLOT_COUNT (SLOT_COUNT)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_command(i_command),
        .i_key    (i_key),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_entry  (o_entry),
        .o_status (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Murmur3 finalizer reduced to a home slot
    function automatic int home_slot(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k ^ (k >> 16);
        h = h * MIX_C1;
        h = h ^ (h >> 13);
        h = h * MIX_C2;
        h = h ^ (h >> 16);
        return int'(h % SLOT_COUNT);
    endfunction

    // Draw random keys until one lands on the requested home slot
    function automatic logic [KEY_W-1:0] key_for_slot(int slot);
        logic [KEY_W-1:0] k;
        k = $urandom;
        while (home_slot(k) != slot) k = $urandom;
        return k;
    endfunction

    // Look up or insert a key in the shadow table and return the answer it gives
    function automatic t_answer predict_lookup(logic cmd, logic [KEY_W-1:0] key);
        t_answer ans;
        int      slot;
        int      tries;
        int      e;
        bit      hit;
        ans.entry = '0;
        ans.status = ST_FULL;
        if (cmd == CMD_INSERT && entries_used >= MAX_ENTRIES) begin
            return ans;
        end
        slot = home_slot(key);
        tries = 0;
        hit = 1'b0;
        e = 0;
        // Walk the cluster until the key or an empty slot turns up
        while (tries < SLOT_COUNT && slot_used[slot]) begin
            e = slot_entry[slot];
            if (e < MAX_ENTRIES && entry_key[e] == key) begin
                hit = 1'b1;
                break;
            end
            slot = (slot + 1) % SLOT_COUNT;
            tries++;
        end
        if (hit) begin
            ans.status = ST_FOUND;
            ans.entry = e[ENTRY_W-1:0];
        end else if (cmd == CMD_FIND) begin
            ans.status = ST_MISSING;
        end else if (tries >= SLOT_COUNT) begin
            ans.status = ST_FULL;
        end else begin
            e = entries_used;
            entries_used++;
            entry_key[e] = key;
            slot_used[slot] = 1'b1;
            slot_entry[slot] = e;
            ans.status = ST_INSERTED;
            ans.entry = e[ENTRY_W-1:0];
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        error_count++;
    endtask

    // Drive one request, hold it until accepted, then queue its expected answer
    task automatic issue_request(logic cmd, logic [KEY_W-1:0] key, logic fixed, t_answer typed);
        t_answer ans;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_key     <= key;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ans = predict_lookup(cmd, key);
        awaited_answers.push_back(fixed ? typed : ans);
        if (cmd == CMD_INSERT) known_keys.push_back(key);
    endtask

    // Pick a random request shaped to hit existing keys and build clusters near the wrap
    task automatic issue_random_request();
        int               r;
        logic [KEY_W-1:0] key;
        r = $urandom_range(99);
        if (r < 30) begin
            issue_request(CMD_INSERT, $urandom, 1'b0, '0);
        end else if (r < 40) begin
            key = key_for_slot((SLOT_COUNT - 2 + $urandom_range(3)) % SLOT_COUNT);
            issue_request(CMD_INSERT, key, 1'b0, '0);
        end else if (r < 60) begin
            key = known_keys[$urandom_range(known_keys.size() - 1)];
            issue_request(CMD_INSERT, key, 1'b0, '0);
        end else if (r < 85) begin
            key = known_keys[$urandom_range(known_keys.size() - 1)];
            issue_request(CMD_FIND, key, 1'b0, '0);
        end else begin
            issue_request(CMD_FIND, $urandom, 1'b0, '0);
        end
    endtask

    // Check each result transaction against the oldest expectation; drive receiver stall
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result entry=%0d status=%0d",
                                          o_entry, o_status));
            end else begin
                exp_ans = awaited_answers.pop_front();
                if (o_entry !== exp_ans.entry)
                    report_mismatch($sformatf("entry got %0d expected %0d",
                                              o_entry, exp_ans.entry));
                if (o_status !== exp_ans.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_status, exp_ans.status));
            end
        end
        i_stall <= ($urandom_range(99) < dst_idle_pct);
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row row;
        t_answer  typed;
        int       phase;
        error_count = 0;
        quiet_cycles = 0;
        entries_used = 0;
        foreach (slot_used[s]) slot_used[s] = 1'b0;
        src_idle_pct = 26;
        dst_idle_pct = 86;

        // Colliding keys all homed on the last slot, so probing wraps to slot zero
        foreach (collide_keys[c]) collide_keys[c] = key_for_slot(SLOT_COUNT - 1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (DIRECTED[n]) begin
            row = DIRECTED[n];
            typed.entry = row.entry;
            typed.status = row.status;
            issue_request(row.cmd, row.use_collide ? collide_keys[row.key] : row.key,
                          row.fixed, typed);
        end

        // Random traffic in three idling phases
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 26;
                    dst_idle_pct = 86;
                end
                1: begin
                    src_idle_pct = 86;
                    dst_idle_pct = 26;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_ITEMS / 3) issue_random_request();
        end

        // Drop valid, drain outstanding results, then let the block settle
        i_valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
